// ----- sv/assert_macros.svh -----
// Assertion helpers. Every check is clocked on clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping form: the consequent is checked on the same edge as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle form: the consequent is checked on the edge after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dwes_pkg.sv -----
package dwes_pkg;

	localparam int unsigned TICK_MS_DEF = 1;

	localparam logic [15:0] SPEED_REF_RST = 16'd15;
	localparam logic [15:0] CTRL_INT_RST  = 16'd20;
	localparam logic [15:0] LED_INT_RST   = 16'd500;
	localparam logic [15:0] PERIOD_RST    = 16'd100;
	localparam logic [7:0]  DUTY_MAX      = 8'd255;

	typedef enum logic [1:0] {
		CFG_SPEED_REF = 2'd0,
		CFG_CTRL_INT  = 2'd1,
		CFG_LED_INT   = 2'd2
	} cfg_idx_t;

	// Result word. The first field sits in the highest bits.
	typedef struct packed {
		logic [5:0]  pad;
		logic        control_fired;
		logic        led_lit;
		logic [15:0] right_pulses;
		logic [15:0] left_pulses;
		logic [15:0] right_interval;
		logic [15:0] left_interval;
		logic [7:0]  right_drive;
		logic [7:0]  left_drive;
	} res_t;

endpackage

// ----- sv/dual_wheel_encoder_speed_stepper_core.sv -----
// Each accepted word goes through the input register, then the result register, to result valid.
// Throughput: one word per cycle while m_tready keeps up. The input register and the result register let a new
// word enter while the previous result still waits on m_tready.
// Reset (arst_n low, asynchronous): registers go to 15/20/500, periods to 100, all counters,
// duties and the LED go to 0, and both stages are emptied.
module dual_wheel_encoder_speed_stepper_core
	import dwes_pkg::*;
#(
	parameter int unsigned TICK_MS = TICK_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // tick, left_pulse, right_pulse, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // left_drive, right_drive, left_interval, right_interval,
	                               // left_pulses, right_pulses, led_lit, control_fired, pad
);

	`include "assert_macros.svh"

	localparam int unsigned TW = $clog2(TICK_MS + 1);
	localparam int unsigned PW = 16 + TW;
	localparam logic [TW-1:0] TICK_LEN = TW'(TICK_MS);

	// config registers
	logic [15:0] speed_ref_q, ctrl_int_q, led_int_q;

	// block state
	logic [15:0] tick_cnt_q, l_last_q, r_last_q, l_period_q, r_period_q;
	logic [15:0] l_count_q, r_count_q, ctrl_cnt_q, led_cnt_q;
	logic [7:0]  l_duty_q, r_duty_q;
	logic        led_q;

	// stages
	logic v_s1, tick_s1, lp_s1, rp_s1;
	logic out_v_q;
	res_t res_q;
	logic adv;

	assign adv      = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_ref_q <= SPEED_REF_RST;
			ctrl_int_q  <= CTRL_INT_RST;
			led_int_q   <= LED_INT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPEED_REF: speed_ref_q <= cfg_data;
				CFG_CTRL_INT:  ctrl_int_q  <= cfg_data;
				CFG_LED_INT:   led_int_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= s_tdata[0];
			lp_s1   <= s_tdata[1];
			rp_s1   <= s_tdata[2];
		end
	end

	// next-state logic for the word in stage 1
	logic [15:0] l_diff, r_diff;
	logic [PW-1:0] l_prod, r_prod;
	logic [15:0] l_period_d, r_period_d, l_last_d, r_last_d, l_count_d, r_count_d;
	logic [15:0] tick_cnt_d, ctrl_cnt_d, led_cnt_d;
	logic [16:0] ctrl_next, led_next;
	logic ctrl_due, led_due, fired;
	logic [7:0] l_duty_d, r_duty_d;
	logic led_d;

	assign l_diff = tick_cnt_q - l_last_q;
	assign r_diff = tick_cnt_q - r_last_q;
	assign l_prod = PW'(l_diff) * PW'(TICK_LEN);
	assign r_prod = PW'(r_diff) * PW'(TICK_LEN);

	assign ctrl_next = {1'b0, ctrl_cnt_q} + 17'd1;
	assign led_next  = {1'b0, led_cnt_q} + 17'd1;
	assign ctrl_due  = ctrl_next >= {1'b0, ctrl_int_q};
	assign led_due   = led_next >= {1'b0, led_int_q};

	always_comb begin
		l_period_d = l_period_q;
		r_period_d = r_period_q;
		l_last_d   = l_last_q;
		r_last_d   = r_last_q;
		l_count_d  = l_count_q;
		r_count_d  = r_count_q;
		tick_cnt_d = tick_cnt_q;
		ctrl_cnt_d = ctrl_cnt_q;
		led_cnt_d  = led_cnt_q;
		l_duty_d   = l_duty_q;
		r_duty_d   = r_duty_q;
		led_d      = led_q;
		fired      = 1'b0;

		// pulses use the tick count from before this word's tick
		if (lp_s1) begin
			l_count_d = l_count_q + 16'd1;
			l_last_d  = tick_cnt_q;
			if (l_last_q != 16'd0)
				l_period_d = (l_prod > PW'(16'hFFFF)) ? 16'hFFFF : l_prod[15:0];
		end
		if (rp_s1) begin
			r_count_d = r_count_q + 16'd1;
			r_last_d  = tick_cnt_q;
			if (r_last_q != 16'd0)
				r_period_d = (r_prod > PW'(16'hFFFF)) ? 16'hFFFF : r_prod[15:0];
		end

		if (tick_s1) begin
			tick_cnt_d = tick_cnt_q + 16'd1;
			ctrl_cnt_d = ctrl_due ? 16'd0 : ctrl_next[15:0];
			led_cnt_d  = led_due ? 16'd0 : led_next[15:0];
			if (ctrl_due) begin
				fired = 1'b1;
				// shorter period than the reference means too fast
				if (l_period_d < speed_ref_q) begin
					if (l_duty_q != 8'd0)
						l_duty_d = l_duty_q - 8'd1;
				end else if (l_duty_q != DUTY_MAX) begin
					l_duty_d = l_duty_q + 8'd1;
				end
				if (r_period_d < speed_ref_q) begin
					if (r_duty_q != 8'd0)
						r_duty_d = r_duty_q - 8'd1;
				end else if (r_duty_q != DUTY_MAX) begin
					r_duty_d = r_duty_q + 8'd1;
				end
			end
			if (led_due)
				led_d = !led_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			l_last_q   <= '0;
			r_last_q   <= '0;
			l_period_q <= PERIOD_RST;
			r_period_q <= PERIOD_RST;
			l_count_q  <= '0;
			r_count_q  <= '0;
			ctrl_cnt_q <= '0;
			led_cnt_q  <= '0;
			l_duty_q   <= '0;
			r_duty_q   <= '0;
			led_q      <= 1'b0;
			out_v_q    <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
			if (v_s1) begin
				tick_cnt_q <= tick_cnt_d;
				l_last_q   <= l_last_d;
				r_last_q   <= r_last_d;
				l_period_q <= l_period_d;
				r_period_q <= r_period_d;
				l_count_q  <= l_count_d;
				r_count_q  <= r_count_d;
				ctrl_cnt_q <= ctrl_cnt_d;
				led_cnt_q  <= led_cnt_d;
				l_duty_q   <= l_duty_d;
				r_duty_q   <= r_duty_d;
				led_q      <= led_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_q.pad            <= '0;
			res_q.control_fired  <= fired;
			res_q.led_lit        <= led_d;
			res_q.right_pulses   <= r_count_d;
			res_q.left_pulses    <= l_count_d;
			res_q.right_interval <= r_period_d;
			res_q.left_interval  <= l_period_d;
			res_q.right_drive    <= r_duty_d;
			res_q.left_drive     <= l_duty_d;
		end
	end

	`CHK_SAME(a_ready_when_empty, !out_v_q, s_tready, "input stalled with empty result register")
	`CHK_NEXT(a_no_tick_holds_cnt, v_s1 && adv && !tick_s1, $stable(tick_cnt_q) && $stable(led_q),
		"tick state moved on a word without a tick")
	`CHK_NEXT(a_fire_needs_tick, v_s1 && adv && !tick_s1, !res_q.control_fired,
		"controller update reported without a tick")
	`CHK_NEXT(a_idle_holds_duty, !(v_s1 && adv), $stable(l_duty_q) && $stable(r_duty_q),
		"duty changed with no word advancing")

endmodule

// ----- bench/stepper_checker.sv -----
module stepper_checker
	import dwes_pkg::*;
#(
	parameter int unsigned TICK_MS = TICK_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // tick, left_pulse, right_pulse, zero pad
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // left_drive, right_drive, left_interval, right_interval,
	                               // left_pulses, right_pulses, led_lit, control_fired, pad
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] speed_target, control_span, led_span;
	logic [15:0] ticks, left_mark, right_mark, left_period, right_period;
	logic [15:0] left_count, right_count, control_count, led_count;
	logic [7:0]  left_duty, right_duty;
	logic        led_on;
	res_t        wheel_status_q[$];

	// period since the last pulse, in ms; a zero mark means no earlier pulse
	function automatic logic [15:0] measure(input logic [15:0] now, mark, old);
		logic [31:0] span;
		if (mark == 16'd0)
			return old;
		span = 32'(16'(now - mark)) * TICK_MS;
		return (span > 32'd65535) ? 16'hFFFF : span[15:0];
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] duty, input logic [15:0] period);
		if (period < speed_target)
			return (duty == 8'd0) ? duty : duty - 8'd1;
		return (duty == DUTY_MAX) ? duty : duty + 8'd1;
	endfunction

	// zero span acts as one: fires every tick
	function automatic logic lapse(input logic [15:0] count, span, output logic [15:0] next_count);
		logic [16:0] bumped;
		bumped = {1'b0, count} + 17'd1;
		next_count = (bumped >= {1'b0, span}) ? 16'd0 : bumped[15:0];
		return bumped >= {1'b0, span};
	endfunction

	function automatic res_t advance_wheels(input logic tk, lp, rp);
		res_t        r;
		logic        fired, toggle;
		logic [15:0] nxt;
		fired = 1'b0;
		// pulses see the tick count from before this word's tick
		if (lp) begin
			left_count = left_count + 16'd1;
			left_period = measure(ticks, left_mark, left_period);
			left_mark = ticks;
		end
		if (rp) begin
			right_count = right_count + 16'd1;
			right_period = measure(ticks, right_mark, right_period);
			right_mark = ticks;
		end
		if (tk) begin
			ticks = ticks + 16'd1;
			fired = lapse(control_count, control_span, nxt);
			control_count = nxt;
			if (fired) begin
				left_duty = nudge(left_duty, left_period);
				right_duty = nudge(right_duty, right_period);
			end
			toggle = lapse(led_count, led_span, nxt);
			led_count = nxt;
			if (toggle)
				led_on = ~led_on;
		end
		r = '0;
		r.left_drive = left_duty;
		r.right_drive = right_duty;
		r.left_interval = left_period;
		r.right_interval = right_period;
		r.left_pulses = left_count;
		r.right_pulses = right_count;
		r.led_lit = led_on;
		r.control_fired = fired;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_status(res_t want, res_t got);
		check_field("left_drive", 16'(want.left_drive), 16'(got.left_drive));
		check_field("right_drive", 16'(want.right_drive), 16'(got.right_drive));
		check_field("left_interval", want.left_interval, got.left_interval);
		check_field("right_interval", want.right_interval, got.right_interval);
		check_field("left_pulses", want.left_pulses, got.left_pulses);
		check_field("right_pulses", want.right_pulses, got.right_pulses);
		check_field("led_lit", 16'(want.led_lit), 16'(got.led_lit));
		check_field("control_fired", 16'(want.control_fired), 16'(got.control_fired));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_target = SPEED_REF_RST;
			control_span = CTRL_INT_RST;
			led_span = LED_INT_RST;
			ticks = '0;
			left_mark = '0;
			right_mark = '0;
			left_period = PERIOD_RST;
			right_period = PERIOD_RST;
			left_count = '0;
			right_count = '0;
			control_count = '0;
			led_count = '0;
			left_duty = '0;
			right_duty = '0;
			led_on = 1'b0;
			wheel_status_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (wheel_status_q.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else
					compare_status(wheel_status_q.pop_front(), res_t'(m_tdata));
			end
			if (s_tvalid && s_tready)
				wheel_status_q.push_back(advance_wheels(s_tdata[0], s_tdata[1], s_tdata[2]));
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPEED_REF: speed_target = cfg_data;
					CFG_CTRL_INT:  control_span = cfg_data;
					CFG_LED_INT:   led_span = cfg_data;
					default: ;
				endcase
			end
			outstanding <= wheel_status_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dwes_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped register index
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	int          mismatches;
	int          outstanding;
	int          quiet = 0;
	bit          calm;
	bit          hold_req;
	bit          hold_done;
	logic [15:0] sent_ticks;

	always #5ns clk = ~clk;

	dual_wheel_encoder_speed_stepper_core DUT (.*);

	stepper_checker checker_i (.*);

	task automatic send_word(input logic tk, lp, rp);
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, rp, lp, tk};
		do @(posedge clk); while (!s_tready);
		if (tk)
			sent_ticks = sent_ticks + 16'd1;
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic settle_and_set(input logic [15:0] sref, cint, lint);
		drain();
		put_reg(CFG_SPEED_REF, sref);
		put_reg(CFG_CTRL_INT, cint);
		put_reg(CFG_LED_INT, lint);
		cfg_we <= 1'b0;
	endtask

	task automatic random_words(input int count, input int pulse_pct);
		repeat (count)
			send_word(1'($urandom_range(1)), $urandom_range(99) < pulse_pct,
				$urandom_range(99) < pulse_pct);
	endtask

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				m_tready <= calm || ($urandom_range(99) >= 24);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		sent_ticks = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every flag mix, first pulses with no earlier mark,
		// short periods driving the duty against its floor
		for (int k = 0; k < 8; k++)
			send_word(k[0], k[1], k[2]);
		repeat (17)
			send_word(1'b1, sent_ticks[1:0] == 2'd1, sent_ticks[2:0] == 3'd3);

		// zero reference and zero intervals: duty climbs to its cap, events every tick
		settle_and_set(16'd0, 16'd0, 16'd0);
		random_words(600, 30);

		settle_and_set(16'hFFFF, 16'd1, 16'd1);
		hold_req = 1'b1;
		random_words(300, 50);

		settle_and_set(16'($urandom_range(20, 2)), 16'($urandom_range(6, 1)),
			16'($urandom_range(12, 1)));
		put_reg(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
		cfg_we <= 1'b0;
		random_words(250, 10);
		settle_and_set(16'($urandom_range(20, 2)), 16'($urandom_range(6, 1)),
			16'($urandom_range(12, 1)));
		random_words(250, 40);
		settle_and_set(16'($urandom_range(20, 2)), 16'($urandom_range(6, 1)),
			16'($urandom_range(12, 1)));
		random_words(250, 80);

		// long stretch with no idling at all on either side
		settle_and_set(16'd9, 16'd2, 16'd5);
		calm = 1'b1;
		random_words(200, 50);
		calm = 1'b0;

		// intervals drop far below the accumulated counts
		settle_and_set(16'd12, 16'd3, 16'd7);
		random_words(200, 35);

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dwes_pkg.sv
sv/dual_wheel_encoder_speed_stepper_core.sv
bench/stepper_checker.sv
bench/tb_top.sv
